@@ hdl/lecb_pkg.sv @@
// Package for the LED error-code blinker: widths, phase and place codes,
// register indexes, reset values, shared types and digit helper functions.
// Has no dependencies.
package lecb_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DUR_W       = 16;
    localparam int CODE_W      = 10;
    localparam int LEN_W       = ((COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W) + 1;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;
    localparam int DIGIT_W     = 4;

    localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(1) << COUNT_WIDTH;
    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(999);

    localparam logic [1:0] PH_LIT  = 2'd0;
    localparam logic [1:0] PH_DARK = 2'd1;
    localparam logic [1:0] PH_DGAP = 2'd2;
    localparam logic [1:0] PH_RGAP = 2'd3;

    localparam logic [1:0] PL_HUND  = 2'd0;
    localparam logic [1:0] PL_TENS  = 2'd1;
    localparam logic [1:0] PL_UNITS = 2'd2;
    localparam logic [1:0] PL_RGAP  = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_CODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ON   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFF  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DGAP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RGAP = 3'd4;

    localparam logic [CODE_W-1:0] RST_CODE = '0;
    localparam logic [DUR_W-1:0]  RST_ON   = DUR_W'(100);
    localparam logic [DUR_W-1:0]  RST_OFF  = DUR_W'(100);
    localparam logic [DUR_W-1:0]  RST_DGAP = DUR_W'(500);
    localparam logic [DUR_W-1:0]  RST_RGAP = DUR_W'(2000);

    typedef struct packed {
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } t_digits;

    typedef struct packed {
        logic [1:0]         phase;
        logic [1:0]         place;
        logic [DIGIT_W-1:0] blinks;
    } t_seq;

    typedef struct packed {
        logic             code_wr;
        t_digits          digits_new;
        logic [DUR_W-1:0] on_ticks;
        logic [DUR_W-1:0] off_ticks;
        logic [DUR_W-1:0] dgap_ticks;
        logic [DUR_W-1:0] rgap_ticks;
    } t_cfg;

    localparam t_seq SEQ_RST = '{phase: PH_RGAP, place: PL_RGAP, blinks: '0};

    // Division by 100 and 10 through reciprocal multiplies; exact for codes up to 999.
    function automatic t_digits code_digits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]  c;
        logic [15:0]        prod_h;
        logic [6:0]         rem;
        logic [14:0]        prod_t;
        logic [DIGIT_W-1:0] h;
        logic [DIGIT_W-1:0] t;
        t_digits            d;
        c      = (code > CODE_MAX) ? CODE_MAX : code;
        prod_h = {6'd0, c} * 16'd41;
        h      = prod_h[15:12];
        rem    = 7'(c - ({6'd0, h} * 10'd100));
        prod_t = {8'd0, rem} * 15'd205;
        t      = prod_t[14:11];
        d.hund  = h;
        d.tens  = t;
        d.units = 4'(rem - ({3'd0, t} * 7'd10));
        return d;
    endfunction

    // First place at or after start that has blinks, else the repeat gap.
    function automatic t_seq enter_place(input t_digits d, input logic [1:0] start);
        t_seq               s;
        logic [DIGIT_W-1:0] dg;
        logic               found;
        s     = SEQ_RST;
        found = 1'b0;
        for (int p = 0; p < 3; p++) begin
            dg = (p == 0) ? d.hund : ((p == 1) ? d.tens : d.units);
            if (!found && (2'(p) >= start) && (dg != '0)) begin
                s.phase = PH_LIT;
                s.place = 2'(p);
                s.blinks = dg;
                found = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

@@ hdl/led_error_code_blinker_core.sv @@
// Top level of the LED error-code blinker: stream ports, result register and
// APB port. Instantiates lecb_cfg_regs and lecb_seq; depends on lecb_pkg.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata[0] tick_elapsed
//   m_axis    out        tdata[0] led_on, tdata[2:1] digit_place
//   apb       in/out     five registers at byte addresses 0, 4, 8, 12, 16
//
// One beat is taken per clock while s_axis_tready is high; its result is captured
// in the output register at the accepting edge, and the sequencer state is updated at the same edge.
// s_axis_tready stays high while the output register is empty or being drained.
// Reset is synchronous and leaves the sequencer in the repeat gap with code 0.
module led_error_code_blinker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] tick_elapsed
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [0] led_on, [2:1] digit_place
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lecb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lecb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lecb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    lecb_pkg::t_cfg cfg;
    logic           accept;
    logic           cur_led_on;
    logic [1:0]     cur_place;
    logic           r_out_valid;
    logic           r_led_on;
    logic [1:0]     r_place;

    assign pready        = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lecb_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    lecb_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (accept),
        .i_tick   (s_axis_tdata[0]),
        .o_led_on (cur_led_on),
        .o_place  (cur_place)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_led_on <= cur_led_on;
            r_place  <= cur_place;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_place, r_led_on};

endmodule

@@ hdl/lecb_cfg_regs.sv @@
// Configuration register bank of the LED error-code blinker with its APB port.
// Depends on lecb_pkg for widths, register indexes, reset values and digit split.
module lecb_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [lecb_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [lecb_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [lecb_pkg::APB_DATA_W-1:0] o_prdata,
    output lecb_pkg::t_cfg                 o_cfg
);

    logic [lecb_pkg::CODE_W-1:0]    r_code;
    logic [lecb_pkg::DUR_W-1:0]     r_on;
    logic [lecb_pkg::DUR_W-1:0]     r_off;
    logic [lecb_pkg::DUR_W-1:0]     r_dgap;
    logic [lecb_pkg::DUR_W-1:0]     r_rgap;
    logic [lecb_pkg::REG_IDX_W-1:0] idx;
    logic                           wr_en;

    assign idx   = i_paddr[lecb_pkg::APB_ADDR_W-1:2];
    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= lecb_pkg::RST_CODE;
            r_on   <= lecb_pkg::RST_ON;
            r_off  <= lecb_pkg::RST_OFF;
            r_dgap <= lecb_pkg::RST_DGAP;
            r_rgap <= lecb_pkg::RST_RGAP;
        end else if (wr_en) begin
            case (idx)
                lecb_pkg::REG_CODE: r_code <= i_pwdata[lecb_pkg::CODE_W-1:0];
                lecb_pkg::REG_ON:   r_on   <= i_pwdata[lecb_pkg::DUR_W-1:0];
                lecb_pkg::REG_OFF:  r_off  <= i_pwdata[lecb_pkg::DUR_W-1:0];
                lecb_pkg::REG_DGAP: r_dgap <= i_pwdata[lecb_pkg::DUR_W-1:0];
                lecb_pkg::REG_RGAP: r_rgap <= i_pwdata[lecb_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            lecb_pkg::REG_CODE: o_prdata = lecb_pkg::APB_DATA_W'(r_code);
            lecb_pkg::REG_ON:   o_prdata = lecb_pkg::APB_DATA_W'(r_on);
            lecb_pkg::REG_OFF:  o_prdata = lecb_pkg::APB_DATA_W'(r_off);
            lecb_pkg::REG_DGAP: o_prdata = lecb_pkg::APB_DATA_W'(r_dgap);
            lecb_pkg::REG_RGAP: o_prdata = lecb_pkg::APB_DATA_W'(r_rgap);
            default:            o_prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.code_wr    = wr_en && (idx == lecb_pkg::REG_CODE);
        o_cfg.digits_new = lecb_pkg::code_digits(i_pwdata[lecb_pkg::CODE_W-1:0]);
        o_cfg.on_ticks   = r_on;
        o_cfg.off_ticks  = r_off;
        o_cfg.dgap_ticks = r_dgap;
        o_cfg.rgap_ticks = r_rgap;
    end

endmodule

@@ hdl/lecb_seq.sv @@
// Blink sequencer of the LED error-code blinker: phase, place, blink count and
// tick counter, stepped by accepted beats with tick set. Depends on lecb_pkg.
module lecb_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lecb_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  logic           i_tick,
    output logic           o_led_on,
    output logic [1:0]     o_place
);

    lecb_pkg::t_seq                     r_seq;
    lecb_pkg::t_seq                     n_seq;
    logic [lecb_pkg::COUNT_WIDTH-1:0]   r_count;
    logic [lecb_pkg::COUNT_WIDTH-1:0]   n_count;
    lecb_pkg::t_digits                  r_digits;
    logic [lecb_pkg::DUR_W-1:0]         len_raw;
    logic [lecb_pkg::LEN_W-1:0]         len;
    logic [lecb_pkg::LEN_W-1:0]         cnt_inc;
    logic [lecb_pkg::DIGIT_W-1:0]       blinks_dec;

    always_comb begin
        case (r_seq.phase)
            lecb_pkg::PH_LIT:  len_raw = i_cfg.on_ticks;
            lecb_pkg::PH_DARK: len_raw = i_cfg.off_ticks;
            lecb_pkg::PH_DGAP: len_raw = i_cfg.dgap_ticks;
            default:           len_raw = i_cfg.rgap_ticks;
        endcase
        if (len_raw == '0) begin
            len = lecb_pkg::LEN_W'(1);
        end else if (lecb_pkg::LEN_W'(len_raw) > lecb_pkg::LEN_CAP) begin
            len = lecb_pkg::LEN_CAP;
        end else begin
            len = lecb_pkg::LEN_W'(len_raw);
        end
        cnt_inc    = lecb_pkg::LEN_W'(r_count) + lecb_pkg::LEN_W'(1);
        blinks_dec = (r_seq.blinks != '0) ? (r_seq.blinks - lecb_pkg::DIGIT_W'(1)) : '0;

        n_seq   = r_seq;
        n_count = r_count;
        if (i_cfg.code_wr) begin
            n_seq   = lecb_pkg::enter_place(i_cfg.digits_new, lecb_pkg::PL_HUND);
            n_count = '0;
        end else if (i_step && i_tick) begin
            if (cnt_inc < len) begin
                n_count = cnt_inc[lecb_pkg::COUNT_WIDTH-1:0];
            end else begin
                n_count = '0;
                case (r_seq.phase)
                    lecb_pkg::PH_LIT: begin
                        n_seq.phase = lecb_pkg::PH_DARK;
                    end
                    lecb_pkg::PH_DARK: begin
                        n_seq.blinks = blinks_dec;
                        if (blinks_dec != '0) begin
                            n_seq.phase = lecb_pkg::PH_LIT;
                        end else if (r_seq.place < lecb_pkg::PL_UNITS) begin
                            n_seq.phase = lecb_pkg::PH_DGAP;
                        end else begin
                            n_seq.place = lecb_pkg::PL_RGAP;
                            n_seq.phase = lecb_pkg::PH_RGAP;
                        end
                    end
                    lecb_pkg::PH_DGAP: begin
                        n_seq = lecb_pkg::enter_place(r_digits, r_seq.place + 2'd1);
                    end
                    default: begin
                        n_seq = lecb_pkg::enter_place(r_digits, lecb_pkg::PL_HUND);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= lecb_pkg::SEQ_RST;
            r_count  <= '0;
            r_digits <= '0;
        end else begin
            r_seq   <= n_seq;
            r_count <= n_count;
            if (i_cfg.code_wr) begin
                r_digits <= i_cfg.digits_new;
            end
        end
    end

    assign o_led_on = (r_seq.phase == lecb_pkg::PH_LIT);
    assign o_place  = r_seq.place;

endmodule
